// ===== rtl/assert_macros.svh =====
// assertion helpers shared by qple_queue and qple_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define QPLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define QPLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/qple_pkg.sv =====
`default_nettype none
package qple_pkg;

  localparam int unsigned LineW = 10;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  localparam logic [LineW-1:0] MAX_LEN_RST = 10'd76;

  // one queued job: optional soft break, then a plain char or an =XX triple
  typedef struct packed {
    logic       brk;
    logic       enc;
    logic [7:0] data;
  } qple_cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h37 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qple_front.sv =====
`default_nettype none
module qple_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  input  wire logic [qple_pkg::LineW-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  input  wire logic                     q_full_i,
  input  wire logic [7:0]               data_byte_i,
  input  wire logic                     final_req_i,
  output logic                          in_ready_o,
  output logic                          push_o,
  output qple_pkg::qple_cmd_t           cmd_o
);
  import qple_pkg::*;

  logic [LineW-1:0] max_len_q, max_len_d;
  logic [LineW-1:0] len_q, len_d;
  logic             accept;
  logic             is_lf;
  logic             plain;
  logic [1:0]       ulen;
  logic [LineW:0]   sum;
  logic             brk;
  logic [LineW-1:0] base;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    is_lf = (data_byte_i == CH_LF);
    if (data_byte_i >= PRINT_LO && data_byte_i <= PRINT_HI) begin
      plain = (data_byte_i != CH_EQ);
    end else begin
      plain = (data_byte_i == CH_TAB) || (data_byte_i == CH_CR) || is_lf;
    end
    ulen = plain ? 2'd1 : 2'd3;
    sum  = {1'b0, len_q} + {{(LineW-1){1'b0}}, ulen};
    // soft break only on a non-empty line that the unit would overrun
    brk  = !is_lf && (len_q != '0) && (sum > {1'b0, max_len_q});
    base = brk ? '0 : len_q;

    len_d = len_q;
    if (accept) begin
      if (final_req_i || is_lf) begin
        len_d = '0;
      end else begin
        len_d = base + {{(LineW-2){1'b0}}, ulen};
      end
    end

    max_len_d = cfg_valid_i ? cfg_data_i : max_len_q;

    cmd_o.brk  = brk;
    cmd_o.enc  = !plain;
    cmd_o.data = data_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      max_len_q <= MAX_LEN_RST;
    end else begin
      len_q     <= len_d;
      max_len_q <= max_len_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qple_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module qple_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire qple_pkg::qple_cmd_t push_data_i,
  input  wire logic                pop_i,
  output logic                     full_o,
  output logic                     empty_o,
  output qple_pkg::qple_cmd_t      head_o
);
  import qple_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  qple_cmd_t        mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `QPLE_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count above depth")
  `QPLE_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `QPLE_ASSERT(a_ptr_gap, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q),
               "empty queue with pointer gap")

endmodule
`default_nettype wire

// ===== rtl/qple_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module qple_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  wire qple_pkg::qple_cmd_t q_head_i,
  output logic                     pop_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [7:0]               out_char_o,
  output logic                     out_last_o
);
  import qple_pkg::*;

  typedef enum logic [2:0] {
    PH_BRK_EQ,
    PH_BRK_CR,
    PH_BRK_LF,
    PH_UNIT,
    PH_HEX_HI,
    PH_HEX_LO
  } phase_e;

  phase_e     phase_q, phase_d;
  qple_cmd_t  cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic       load, emit, done;
  logic [7:0] ch;

  assign load        = !out_valid_q || out_ready_i;
  assign emit        = cur_valid_q && load;
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    unique case (phase_q)
      PH_BRK_EQ: ch = CH_EQ;
      PH_BRK_CR: ch = CH_CR;
      PH_BRK_LF: ch = CH_LF;
      PH_UNIT:   ch = cur_q.enc ? CH_EQ : cur_q.data;
      PH_HEX_HI: ch = hex_char(cur_q.data[7:4]);
      PH_HEX_LO: ch = hex_char(cur_q.data[3:0]);
      default:   ch = CH_EQ;
    endcase
    done = cur_q.enc ? (phase_q == PH_HEX_LO) : (phase_q == PH_UNIT);

    // pull the next job when idle or on the final char of this one
    pop_o       = !q_empty_i && (!cur_valid_q || (emit && done));
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    phase_d     = phase_q;
    if (pop_o) begin
      cur_d       = q_head_i;
      cur_valid_d = 1'b1;
      phase_d     = q_head_i.brk ? PH_BRK_EQ : PH_UNIT;
    end else if (emit && done) begin
      cur_valid_d = 1'b0;
    end else if (emit) begin
      phase_d = phase_e'(phase_q + 3'd1);
    end

    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_char_d  = ch;
      out_last_d  = done;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_UNIT;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_char_q <= out_char_d;
  end

  `QPLE_ASSERT(a_plain_no_hex,
               (cur_valid_q && !cur_q.enc) |-> (phase_q != PH_HEX_HI && phase_q != PH_HEX_LO),
               "hex phase on plain char")
  `QPLE_ASSERT(a_nobrk_skip,
               (cur_valid_q && !cur_q.brk) |->
                 (phase_q != PH_BRK_EQ && phase_q != PH_BRK_CR && phase_q != PH_BRK_LF),
               "break phase without break")
  `QPLE_ASSERT(a_pop_ok, pop_o |-> (!cur_valid_q || (emit && done)), "pop while job busy")

endmodule
`default_nettype wire

// ===== rtl/quoted_printable_line_encoder_top.sv =====
`default_nettype none
// Quoted-printable encoder: one raw byte per input word, one encoded character per
// output word. Printable bytes other than '=', and tab, CR and LF, pass as one
// character; any other byte becomes '=' plus two uppercase hex digits. Before a unit
// that would push a non-empty line past max_line_len a soft break "=" CR LF goes out, so a
// triple is never split. LF clears the line count and never breaks; s_axis_tlast
// marks the end of a message and clears the count after that byte. m_axis_tlast
// flags the last character produced by each input byte. Rate: the front takes one
// byte per cycle while the job queue has room; the back emits one character per
// cycle while the receiver is ready, from the single output character register. The
// first character of a byte passes the job queue, the current-job register and the
// output character register before it is offered. max_line_len (reset 76) is written
// over the cfg port, always ready; only while idle, a user rule the block does not enforce.
module quoted_printable_line_encoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config: max_line_len
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [9:0]  cfg_data_i,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // final_req
  // output words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tlast    // last_of_run
);
  import qple_pkg::*;

  qple_cmd_t push_cmd;
  qple_cmd_t head_cmd;
  logic      push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  // front: classify byte, run line counter, decide soft break
  qple_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .q_full_i    (q_full),
    .data_byte_i (s_axis_tdata),
    .final_req_i (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // short job queue decouples the two sides
  qple_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  // back: expand each job into characters
  qple_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== verif/quoted_printable_line_encoder_top_tb.sv =====
`default_nettype none
module quoted_printable_line_encoder_top_tb;
  import qple_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;  // cycles with no handshake at all
  localparam int unsigned DrainCycles = 8;       // settle time once every char has come back
  localparam int unsigned HoldCycles = 150;      // long receiver hold-off
  localparam int unsigned HoldAfter = 40;        // start hold-off after this many bytes

  // one raw input word
  typedef struct {
    logic [7:0] data;
    logic       fin;
  } raw_word_t;

  // one encoded output word
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } qp_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  quoted_printable_line_encoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tlast  (s_axis_tlast),   // final_req
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_char
    .m_axis_tlast  (m_axis_tlast)    // last_of_run
  );

  always #5 clk_i = ~clk_i;

  // raw bytes waiting to be offered, encoded chars waiting to come back
  raw_word_t raw_byte_q[$];
  qp_word_t  qp_text_q[$];

  // predictor state: line counter and the configured maximum
  int unsigned line_len = 0;
  int unsigned max_len = MAX_LEN_RST;

  // bookkeeping
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned chars_seen = 0;
  int unsigned soft_breaks = 0;
  int unsigned escapes = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // idling knobs, percent of cycles
  int unsigned tx_idle_pct = 21;
  int unsigned rx_idle_pct = 84;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + 8'(nib);
    end
    return 8'h41 + 8'(nib) - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic last);
    qp_word_t w;
    w.ch = ch;
    w.last = last;
    qp_text_q.push_back(w);
  endfunction

  // work out the encoded chars of one raw byte and advance the line counter
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic        plain;
    int unsigned ulen;
    if (b == CH_LF) begin
      // line feed passes as is and restarts the line, never a break
      push_char(b, 1'b1);
      line_len = 0;
    end else begin
      if (b >= PRINT_LO && b <= PRINT_HI) begin
        plain = (b != CH_EQ);
      end else begin
        plain = (b == CH_TAB) || (b == CH_CR);
      end
      ulen = plain ? 1 : 3;
      // soft break only on a non-empty line, so a triple never splits
      if (line_len != 0 && line_len + ulen > max_len) begin
        push_char(CH_EQ, 1'b0);
        push_char(CH_CR, 1'b0);
        push_char(CH_LF, 1'b0);
        line_len = 0;
        soft_breaks++;
      end
      if (plain) begin
        push_char(b, 1'b1);
      end else begin
        push_char(CH_EQ, 1'b0);
        push_char(hex_glyph(b[7:4]), 1'b0);
        push_char(hex_glyph(b[3:0]), 1'b1);
        escapes++;
      end
      line_len = (line_len + ulen) & 32'h3FF;
    end
    // end of message restarts the line for the next one
    if (fin) begin
      line_len = 0;
    end
  endfunction

  // sender: offers queued bytes, predicts each one as it is taken
  always @(posedge clk_i) begin
    raw_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (raw_byte_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          w = raw_byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= w.data;
          s_axis_tlast <= w.fin;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each char against the oldest prediction and throttles ready
  always @(posedge clk_i) begin
    qp_word_t w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        chars_seen++;
        if (qp_text_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected char 0x%02h last %0b", m_axis_tdata, m_axis_tlast);
          end
        end else begin
          w = qp_text_q.pop_front();
          if (m_axis_tdata !== w.ch) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("out_char: expected 0x%02h, got 0x%02h", w.ch, m_axis_tdata);
            end
          end
          if (m_axis_tlast !== w.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("last_of_run on 0x%02h: expected %0b, got %0b",
                       w.ch, w.last, m_axis_tlast);
            end
          end
        end
      end
      // one long hold-off while the sender keeps going, so the job queue fills
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && bytes_taken >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog: too long without any word moving on any port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("quoted_printable_line_encoder_top_tb failed");
        $finish;
      end
    end
  end

  function automatic void queue_byte(input logic [7:0] data, input logic fin);
    raw_word_t w;
    w.data = data;
    w.fin = fin;
    raw_byte_q.push_back(w);
    bytes_queued++;
  endfunction

  // mostly text-like bytes, some escapes, line ends and message ends
  function automatic void queue_random_text(input int unsigned count);
    int unsigned pick;
    logic [7:0]  data;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        data = 8'($urandom_range(255));
      end else if (pick < 24) begin
        data = CH_LF;
      end else if (pick < 26) begin
        data = CH_CR;
      end else if (pick < 28) begin
        data = CH_TAB;
      end else begin
        data = 8'($urandom_range(PRINT_HI, PRINT_LO));
      end
      queue_byte(data, $urandom_range(99) < 4);
    end
  endfunction

  // wait until every byte is taken and every char has come back, then settle
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (bytes_taken != bytes_queued || qp_text_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write max_line_len while the block is idle
  task automatic set_max_len(input logic [9:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    max_len = value;
    cfg_writes++;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset maximum: byte classes at their edges, message end on the last
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(PRINT_LO, 1'b0);
    queue_byte(PRINT_HI, 1'b0);
    queue_byte(CH_EQ, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(CH_TAB, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte(CH_CR, 1'b1);

    // maximum of four: exact fit, break before plain, break before triple
    set_max_len(10'd4);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h62, 1'b0);
    queue_byte(8'h63, 1'b0);
    queue_byte(8'h64, 1'b0);
    queue_byte(8'h65, 1'b0);
    queue_byte(8'h66, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'hA9, 1'b0);
    // line feed on a non-empty line, then CR and tab counted like text
    queue_byte(CH_LF, 1'b0);
    queue_byte(CH_CR, 1'b0);
    queue_byte(CH_TAB, 1'b0);
    queue_byte(8'h67, 1'b0);
    // fills the line exactly, message end clears it, so the triple does not break
    queue_byte(8'h68, 1'b1);
    queue_byte(8'h9F, 1'b0);

    // sender sparse idling, receiver heavy idling; hold-off lands in here
    queue_random_text(40);
    set_max_len(10'd1023);
    queue_random_text(40);

    // maximum below a triple's length: triples sit on lines of their own
    set_max_len(10'd2);
    tx_idle_pct = 84;
    rx_idle_pct = 21;
    queue_random_text(20);

    set_max_len(10'($urandom_range(40, 4)));
    queue_random_text(40);

    // full rate both ways
    set_max_len(MAX_LEN_RST);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_text(20);

    wait_drained();
    $display("%0d bytes in, %0d chars out, %0d escapes, %0d soft breaks",
             bytes_taken, chars_seen, escapes, soft_breaks);
    $display("%0d max_line_len writes, %0d mismatches", cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("quoted_printable_line_encoder_top_tb passed");
    end else begin
      $display("quoted_printable_line_encoder_top_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
